### src/sqrtx_pkg.sv
`default_nettype none

package sqrtx_pkg;

    localparam int SLOTS          = 16;
    localparam int SLOT_BITS      = 4;
    localparam int HANDLE_BITS    = 16;
    localparam int TIME_BITS      = 32;
    localparam int COUNT_BITS     = 5;
    localparam int TRY_BITS       = 4;
    localparam int INTERVAL_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [INTERVAL_BITS-1:0] TIMEOUT_RESET   = 16'd200;
    localparam logic [TRY_BITS-1:0]      MAX_TRIES_RESET = 4'd3;
    localparam logic [INTERVAL_BITS-1:0] GAP_RESET       = 16'd100;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_ENQ  = 2'd1,
        CMD_ACK  = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_RESPONSE_TIMEOUT = 2'd0,
        CFG_MAX_TRIES        = 2'd1,
        CFG_FRAME_GAP        = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_CHECK = 3'd0,
        PH_INIT  = 3'd1,
        PH_SEND  = 3'd2,
        PH_WAIT  = 3'd3,
        PH_END   = 3'd4
    } phase_t;

    typedef struct packed {
        cmd_t                   cmd;
        logic [TIME_BITS-1:0]   now_time;
        logic [HANDLE_BITS-1:0] msg_handle;
    } in_item_t;

    typedef struct packed {
        logic                   tx_valid;
        logic [HANDLE_BITS-1:0] tx_handle;
        logic [SLOT_BITS-1:0]   tx_slot;
        logic                   enq_accepted;
        logic                   finished;
        logic                   dropped;
        logic [COUNT_BITS-1:0]  pending;
    } out_item_t;

    typedef struct packed {
        logic load_out;
        logic enq;
        logic scan;
        logic clear_tries;
        logic send;
        logic retry;
        logic free;
        logic dropped;
    } ctrl_cmd_t;

    typedef struct packed {
        logic pending_nz;
        logic found;
        logic timed_out;
        logic retry_left;
        logic gap_over;
    } dp_status_t;

endpackage

`default_nettype wire

### src/sqrtx_dp.sv
`default_nettype none

module sqrtx_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [sqrtx_pkg::TIME_BITS-1:0]      now_time,
    input  logic [sqrtx_pkg::HANDLE_BITS-1:0]    msg_handle,
    input  sqrtx_pkg::ctrl_cmd_t                 ctrl,
    input  logic                                 cfg_we,
    input  logic [sqrtx_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [sqrtx_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output sqrtx_pkg::dp_status_t                status,
    output sqrtx_pkg::out_item_t                 out_data
);
    import sqrtx_pkg::*;

    logic [SLOTS-1:0]         slot_full_reg, slot_full_next;
    logic [HANDLE_BITS-1:0]   slot_handle_reg [SLOTS];
    logic [COUNT_BITS-1:0]    pending_reg, pending_next;
    logic [SLOT_BITS-1:0]     scan_ptr_reg, scan_ptr_next;
    logic [SLOT_BITS-1:0]     active_slot_reg, active_slot_next;
    logic [TIME_BITS-1:0]     sent_time_reg, sent_time_next;
    logic [TIME_BITS-1:0]     done_time_reg, done_time_next;
    logic [TRY_BITS-1:0]      try_count_reg, try_count_next;
    logic [INTERVAL_BITS-1:0] timeout_reg;
    logic [TRY_BITS-1:0]      max_tries_reg;
    logic [INTERVAL_BITS-1:0] gap_reg;
    out_item_t                out_data_reg, out_data_next;

    logic                     found;
    logic [SLOT_BITS-1:0]     scan_idx;
    logic                     has_free;
    logic [SLOT_BITS-1:0]     free_idx;
    logic                     enq_ok;
    logic [TRY_BITS-1:0]      tries_inc;

    // first occupied slot at or above the scan pointer
    always_comb
    begin
        found    = 1'b0;
        scan_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (slot_full_reg[i] && (SLOT_BITS'(i) >= scan_ptr_reg))
            begin
                found    = 1'b1;
                scan_idx = SLOT_BITS'(i);
            end
        end
    end

    // first empty slot
    always_comb
    begin
        has_free = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!slot_full_reg[i])
            begin
                has_free = 1'b1;
                free_idx = SLOT_BITS'(i);
            end
        end
    end

    assign enq_ok    = ctrl.enq & has_free;
    assign tries_inc = try_count_reg + TRY_BITS'(1);

    assign status.pending_nz = (pending_reg != '0);
    assign status.found      = found;
    assign status.retry_left = (tries_inc < max_tries_reg);
    assign status.timed_out  =
        ((now_time - sent_time_reg) > TIME_BITS'(timeout_reg));
    assign status.gap_over   =
        ((now_time - done_time_reg) > TIME_BITS'(gap_reg));

    always_comb
    begin
        slot_full_next   = slot_full_reg;
        pending_next     = pending_reg;
        scan_ptr_next    = scan_ptr_reg;
        active_slot_next = active_slot_reg;
        sent_time_next   = sent_time_reg;
        done_time_next   = done_time_reg;
        try_count_next   = try_count_reg;

        if (enq_ok)
        begin
            slot_full_next[free_idx] = 1'b1;
            pending_next             = pending_reg + COUNT_BITS'(1);
        end

        if (ctrl.scan)
        begin
            if (found)
            begin
                active_slot_next = scan_idx;
                scan_ptr_next    = (scan_idx == SLOT_BITS'(SLOTS - 1)) ?
                                   '0 : scan_idx + SLOT_BITS'(1);
            end
            else
            begin
                scan_ptr_next = '0;
            end
        end

        if (ctrl.clear_tries)
            try_count_next = '0;
        if (ctrl.retry)
            try_count_next = tries_inc;
        if (ctrl.send)
            sent_time_next = now_time;

        if (ctrl.free)
        begin
            slot_full_next[active_slot_reg] = 1'b0;
            if (pending_reg != '0)
                pending_next = pending_reg - COUNT_BITS'(1);
            done_time_next = now_time;
        end
    end

    always_comb
    begin
        out_data_next.tx_valid     = ctrl.send;
        out_data_next.tx_handle    = ctrl.send ? slot_handle_reg[active_slot_reg] : '0;
        out_data_next.tx_slot      = ctrl.send ? active_slot_reg : '0;
        out_data_next.enq_accepted = enq_ok;
        out_data_next.finished     = ctrl.free;
        out_data_next.dropped      = ctrl.dropped;
        out_data_next.pending      = pending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_full_reg   <= '0;
            pending_reg     <= '0;
            scan_ptr_reg    <= '0;
            active_slot_reg <= '0;
            sent_time_reg   <= '0;
            done_time_reg   <= '0;
            try_count_reg   <= '0;
        end
        else
        begin
            slot_full_reg   <= slot_full_next;
            pending_reg     <= pending_next;
            scan_ptr_reg    <= scan_ptr_next;
            active_slot_reg <= active_slot_next;
            sent_time_reg   <= sent_time_next;
            done_time_reg   <= done_time_next;
            try_count_reg   <= try_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= TIMEOUT_RESET;
            max_tries_reg <= MAX_TRIES_RESET;
            gap_reg       <= GAP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RESPONSE_TIMEOUT: timeout_reg   <= cfg_data[INTERVAL_BITS-1:0];
                CFG_MAX_TRIES:        max_tries_reg <= cfg_data[TRY_BITS-1:0];
                CFG_FRAME_GAP:        gap_reg       <= cfg_data[INTERVAL_BITS-1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq_ok)
            slot_handle_reg[free_idx] <= msg_handle;
        if (ctrl.load_out)
            out_data_reg <= out_data_next;
    end

    assign out_data = out_data_reg;

endmodule

`default_nettype wire

### src/sqrtx_ctrl.sv
`default_nettype none

module sqrtx_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  sqrtx_pkg::cmd_t        cmd,
    input  logic                   out_stall,
    input  sqrtx_pkg::dp_status_t  status,
    output logic                   in_stall,
    output logic                   out_valid,
    output sqrtx_pkg::ctrl_cmd_t   ctrl
);
    import sqrtx_pkg::*;

    phase_t phase_reg, phase_next;
    logic   have_work_reg, have_work_next;
    logic   ack_seen_reg, ack_seen_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   tick;

    assign in_stall  = out_valid_reg & out_stall;
    assign accept    = in_valid & ~in_stall;
    assign tick      = accept && (cmd == CMD_TICK);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        out_valid_next = accept | (out_valid_reg & out_stall);
    end

    // next state
    always_comb
    begin
        phase_next     = phase_reg;
        have_work_next = have_work_reg;
        ack_seen_next  = ack_seen_reg;

        if (accept && (cmd == CMD_ACK))
            ack_seen_next = 1'b1;

        if (tick)
        begin
            case (phase_reg)
                PH_CHECK:
                begin
                    if (status.pending_nz)
                    begin
                        have_work_next = status.found;
                        if (status.found)
                            phase_next = PH_INIT;
                    end
                end
                PH_INIT:
                begin
                    if (have_work_reg)
                    begin
                        have_work_next = 1'b0;
                        ack_seen_next  = 1'b0;
                        phase_next     = PH_SEND;
                    end
                end
                PH_SEND:
                    phase_next = PH_WAIT;
                PH_WAIT:
                begin
                    if (!ack_seen_reg && status.timed_out)
                        phase_next = status.retry_left ? PH_SEND : PH_END;
                    else if (ack_seen_reg)
                        phase_next = PH_END;
                end
                PH_END:
                begin
                    if (status.gap_over)
                        phase_next = PH_CHECK;
                end
                default:
                    phase_next = PH_CHECK;
            endcase
        end
    end

    // datapath commands
    always_comb
    begin
        ctrl             = '0;
        ctrl.load_out    = accept;
        ctrl.enq         = accept && (cmd == CMD_ENQ);

        if (tick)
        begin
            case (phase_reg)
                PH_CHECK:
                    ctrl.scan = status.pending_nz;
                PH_INIT:
                    ctrl.clear_tries = have_work_reg;
                PH_SEND:
                    ctrl.send = 1'b1;
                PH_WAIT:
                begin
                    if (!ack_seen_reg && status.timed_out)
                    begin
                        ctrl.retry = 1'b1;
                        if (!status.retry_left)
                        begin
                            ctrl.free    = 1'b1;
                            ctrl.dropped = 1'b1;
                        end
                    end
                    else if (ack_seen_reg)
                    begin
                        ctrl.free = 1'b1;
                    end
                end
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_CHECK;
            have_work_reg <= 1'b0;
            ack_seen_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            have_work_reg <= have_work_next;
            ack_seen_reg  <= ack_seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### src/slot_queue_retry_transmitter.sv
`default_nettype none

// Slot queue with a round-robin sender that retries on timeout. Every command
// (tick, enqueue, acknowledge, no-op) completes in the cycle its beat is
// accepted and gives exactly one result beat, so the block takes one item per
// clock; the slot scan and the free-slot search are combinational priority
// encoders over the occupancy bitmap. Results sit in one output register, and
// the input stalls only while that register holds a beat that the output side
// is stalling. No clearing pass is needed after reset. Configuration writes go
// straight to the timeout, try-limit and gap registers.
module slot_queue_retry_transmitter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  sqrtx_pkg::in_item_t                  in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output sqrtx_pkg::out_item_t                 out_data,
    input  logic                                 cfg_we,
    input  logic [sqrtx_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [sqrtx_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import sqrtx_pkg::*;

    ctrl_cmd_t  ctrl;
    dp_status_t status;

    sqrtx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cmd       (in_data.cmd),
        .out_stall (out_stall),
        .status    (status),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .ctrl      (ctrl)
    );

    sqrtx_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .now_time   (in_data.now_time),
        .msg_handle (in_data.msg_handle),
        .ctrl       (ctrl),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .status     (status),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire
